[hw/rtl/tpf_pkg.sv]
// ----------------------------------------------------------------------------
// Token packet framer package
// Shared constants, the frame byte selector and the controller/datapath
// command and status bundles, plus the CRC-8 byte update.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int BYTE_W          = 8;
    localparam int LIMIT_W         = 5;
    localparam int DEF_MAX_PAYLOAD = 25;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd25;

    localparam logic [BYTE_W-1:0] SYNC_A   = 8'hC3;
    localparam logic [BYTE_W-1:0] SYNC_B   = 8'h3C;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    // Bit positions inside the flags byte.
    localparam int FLG_START_BIT = 0;
    localparam int FLG_END_BIT   = 1;

    // Which frame byte the datapath drives into the output register.
    typedef enum logic [2:0] {
        BSEL_SYNC_A,
        BSEL_SYNC_B,
        BSEL_MSG_ID,
        BSEL_SEQ,
        BSEL_FLAGS,
        BSEL_LEN,
        BSEL_PAY,
        BSEL_CRC
    } t_byte_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      in_ready;
        logic      emit;
        t_byte_sel sel;
        logic      crc_clr;
        logic      rd_first;
        logic      rd_next;
        logic      finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic frame_start;
        logic pay_last;
    } t_dp_sts;

    // CRC-8, polynomial 0x07, MSB first, one byte per call.
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_MSB) != CRC_INIT) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/tpf_ctrl.sv]
// ----------------------------------------------------------------------------
// Token packet framer controller
// Walks the frame layout one byte per output slot and issues the byte
// select, CRC and chunk-read commands to the datapath.
// ----------------------------------------------------------------------------
module tpf_ctrl
    import tpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC_A,
        S_SYNC_B,
        S_MSG_ID,
        S_SEQ,
        S_FLAGS,
        S_LEN,
        S_PAY,
        S_CRC
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: idle waits for a completing request; any other state moves
    // on once its byte (payload: its last byte) is in the output register.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_sts.frame_start) n_state = S_SYNC_A;
            S_SYNC_A: if (i_sts.out_free) n_state = S_SYNC_B;
            S_SYNC_B: if (i_sts.out_free) n_state = S_MSG_ID;
            S_MSG_ID: if (i_sts.out_free) n_state = S_SEQ;
            S_SEQ:    if (i_sts.out_free) n_state = S_FLAGS;
            S_FLAGS:  if (i_sts.out_free) n_state = S_LEN;
            S_LEN:    if (i_sts.out_free) n_state = S_PAY;
            S_PAY:    if (i_sts.out_free && i_sts.pay_last) n_state = S_CRC;
            S_CRC:    if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode.
    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = BSEL_SYNC_A;
        o_cmd.in_ready = (r_state == S_IDLE);
        o_cmd.emit     = (r_state != S_IDLE) && i_sts.out_free;
        unique case (r_state)
            S_IDLE:   o_cmd.sel = BSEL_SYNC_A;
            S_SYNC_A: begin
                o_cmd.sel     = BSEL_SYNC_A;
                o_cmd.crc_clr = 1'b1;
            end
            S_SYNC_B: o_cmd.sel = BSEL_SYNC_B;
            S_MSG_ID: o_cmd.sel = BSEL_MSG_ID;
            S_SEQ:    o_cmd.sel = BSEL_SEQ;
            S_FLAGS:  o_cmd.sel = BSEL_FLAGS;
            S_LEN: begin
                o_cmd.sel      = BSEL_LEN;
                o_cmd.rd_first = i_sts.out_free;
            end
            S_PAY: begin
                o_cmd.sel     = BSEL_PAY;
                o_cmd.rd_next = i_sts.out_free && !i_sts.pay_last;
            end
            S_CRC: begin
                o_cmd.sel    = BSEL_CRC;
                o_cmd.finish = i_sts.out_free;
            end
            default:  o_cmd.sel = BSEL_SYNC_A;
        endcase
    end

endmodule

[hw/rtl/tpf_dp.sv]
// ----------------------------------------------------------------------------
// Token packet framer datapath
// Chunk memory, fill and frame counters, running CRC, limit register and
// the output register of the frame byte channel.
// ----------------------------------------------------------------------------
module tpf_dp
    import tpf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_in_valid,
    input  logic [BYTE_W-1:0]  i_token,
    input  logic               i_last_token,
    input  logic               i_cfg_valid,
    input  logic [LIMIT_W-1:0] i_cfg_payload_limit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_frame_byte,
    output logic               o_frame_last
);

    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = (FW > LIMIT_W) ? FW : LIMIT_W;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;

    logic [LIMIT_W-1:0] r_limit;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_pay_idx;
    logic [BYTE_W-1:0]  r_msg_id;
    logic [BYTE_W-1:0]  r_seq;
    logic               r_first_pending;
    logic               r_last_flag;
    logic [BYTE_W-1:0]  r_crc;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;

    logic              accept;
    logic [FW-1:0]     fill_inc;
    logic [CW-1:0]     eff_limit;
    logic              frame_due;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] sel_byte;
    logic [BYTE_W-1:0] crc_base;
    logic [FW-1:0]     pay_next;
    logic [AW-1:0]     rd_addr;

    // Effective limit: zero acts as one, anything above the buffer acts as full.
    always_comb begin
        eff_limit = CW'(r_limit);
        if (r_limit == '0) begin
            eff_limit = CW'(1);
        end else if (CW'(r_limit) > CW'(MAX_PAYLOAD)) begin
            eff_limit = CW'(MAX_PAYLOAD);
        end
    end

    // A token completes a chunk if it is the last token or fills it to the limit.
    assign accept    = i_in_valid && i_cmd.in_ready;
    assign fill_inc  = r_fill + FW'(1);
    assign frame_due = i_last_token || (CW'(fill_inc) >= eff_limit);

    assign pay_next = r_pay_idx + FW'(1);
    assign rd_addr  = i_cmd.rd_first ? '0 : pay_next[AW-1:0];

    // Status back to the controller.
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.frame_start = accept && frame_due;
    assign o_sts.pay_last    = (r_pay_idx == FW'(r_fill - FW'(1)));

    // Flags byte.
    always_comb begin
        flags                = '0;
        flags[FLG_START_BIT] = r_first_pending;
        flags[FLG_END_BIT]   = r_last_flag;
    end

    // Frame byte selection.
    always_comb begin
        unique case (i_cmd.sel)
            BSEL_SYNC_A: sel_byte = SYNC_A;
            BSEL_SYNC_B: sel_byte = SYNC_B;
            BSEL_MSG_ID: sel_byte = r_msg_id;
            BSEL_SEQ:    sel_byte = r_seq;
            BSEL_FLAGS:  sel_byte = flags;
            BSEL_LEN:    sel_byte = BYTE_W'(r_fill);
            BSEL_PAY:    sel_byte = r_rd_data;
            BSEL_CRC:    sel_byte = r_crc;
            default:     sel_byte = r_crc;
        endcase
    end

    assign crc_base = i_cmd.crc_clr ? CRC_INIT : r_crc;

    // Chunk memory: write on every accepted token, registered read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_fill[AW-1:0]] <= i_token;
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers: CRC, payload index, output byte, last flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= (i_cmd.sel == BSEL_CRC);
            if (i_cmd.sel != BSEL_CRC) begin
                r_crc <= crc8_byte(crc_base, sel_byte);
            end
        end
        if (i_cmd.rd_first) begin
            r_pay_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_pay_idx <= pay_next;
        end
        if (o_sts.frame_start) begin
            r_last_flag <= i_last_token;
        end
    end

    // Control registers: limit, counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit         <= LIMIT_RESET;
            r_fill          <= '0;
            r_msg_id        <= '0;
            r_seq           <= '0;
            r_first_pending <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_payload_limit;
            end
            if (accept) begin
                r_fill <= fill_inc;
            end
            if (o_sts.frame_start && r_first_pending) begin
                r_msg_id <= r_msg_id + BYTE_W'(1);
            end
            if (i_cmd.finish) begin
                r_fill          <= '0;
                r_seq           <= r_seq + BYTE_W'(1);
                r_first_pending <= r_last_flag;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;

endmodule

[hw/rtl/token_packet_framer.sv]
// ----------------------------------------------------------------------------
// Token packet framer
// Buffers message tokens into chunks and sends each chunk as a framed packet:
// C3 3C, message id, sequence, flags, length, payload, CRC-8 (poly 0x07).
//
// Input channel (i_in_valid / o_in_ready): one token per request, with
// i_last_token marking the end of a message. A token that does not close a
// chunk leaves the input ready. A token that closes a chunk (chunk at the
// limit or last token) starts a frame; the input stays blocked until the
// frame's CRC byte has entered the output register.
// Output channel (o_out_valid / i_out_ready): one frame byte per request,
// o_frame_last on the CRC byte. A frame of n payload bytes is n + 7 bytes,
// sent one byte per cycle through the single output register while the
// receiver keeps ready. The first byte enters the output register from the
// first sync state, which follows the acceptance of the closing token.
// Configuration (i_cfg_valid / o_cfg_ready): payload limit, always ready.
// When the receiver stalls, frame building pauses with the byte held.
// Reset (synchronous, active low) empties the chunk, clears the message id
// and sequence, sets the limit to 25 and empties the output register.
// ----------------------------------------------------------------------------
module token_packet_framer
    import tpf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_token,
    input  logic               i_last_token,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_payload_limit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_frame_byte,
    output logic               o_frame_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Frame sequencer.
    tpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Chunk storage, counters, CRC and output register.
    tpf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_in_valid          (i_in_valid),
        .i_token             (i_token),
        .i_last_token        (i_last_token),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_payload_limit (i_cfg_payload_limit),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_frame_byte        (o_frame_byte),
        .o_frame_last        (o_frame_last)
    );

    assign o_in_ready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

[verif/token_packet_framer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token packet framer testbench
// Sends token requests through a bursty driver while the frame receiver
// stalls on its own pattern. A local frame predictor tracks the chunk buffer,
// the message id and the sequence, and builds every expected frame byte with
// its CRC-8. The monitor checks each accepted frame byte against the oldest
// prediction. Directed cases come first, then random messages over several
// payload limit settings.
// ----------------------------------------------------------------------------
module testbench;
    import tpf_pkg::*;

    localparam int MAX_PAY       = DEF_MAX_PAYLOAD;
    localparam int RAND_ITEMS    = 420;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 10_000_000;

    // One token request and one frame byte as the monitor sees it.
    typedef struct packed {
        logic [BYTE_W-1:0] tok;
        logic              is_last;
    } t_token_req;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } t_frame_beat;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic               i_clk               = 1'b0;
    logic               i_rst_n             = 1'b0;
    logic               i_in_valid          = 1'b0;
    logic [BYTE_W-1:0]  i_token             = '0;
    logic               i_last_token        = 1'b0;
    logic               i_cfg_valid         = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_payload_limit = '0;
    logic               i_out_ready         = 1'b0;
    logic               o_in_ready;
    logic               o_cfg_ready;
    logic               o_out_valid;
    logic [BYTE_W-1:0]  o_frame_byte;
    logic               o_frame_last;

    t_token_req  pending_tokens[$];
    t_frame_beat frame_expect[$];

    // Predictor state, at its reset values.
    logic [BYTE_W-1:0]  pm_chunk[MAX_PAY];
    int                 pm_fill     = 0;
    logic [BYTE_W-1:0]  pm_msg_id   = '0;
    logic [BYTE_W-1:0]  pm_seq      = '0;
    logic               pm_first    = 1'b1;
    logic [LIMIT_W-1:0] cfg_limit   = LIMIT_RESET;

    // Run statistics.
    int tok_count   = 0;
    int frame_count = 0;
    int byte_count  = 0;
    int cfg_writes  = 0;
    int error_count = 0;
    int holds_done  = 0;

    // Driver and receiver bookkeeping.
    logic       tok_taken  = 1'b0;
    int         gap_left   = 0;
    int         burst_left = 8;
    t_token_req cur_req;
    int         hold_left  = 0;
    int         rx_span    = 0;
    int         rx_tick    = 0;
    t_rx_mode   rx_mode    = RX_FREE;

    token_packet_framer #(
        .MAX_PAYLOAD(MAX_PAY)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_token            (i_token),
        .i_last_token       (i_last_token),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_payload_limit(i_cfg_payload_limit),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frame_byte       (o_frame_byte),
        .o_frame_last       (o_frame_last)
    );

    // Free-running clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // CRC-8 over one byte, polynomial 0x07, MSB first.
    function automatic logic [BYTE_W-1:0] crc8_next(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] r;
        r = acc ^ b;
        repeat (BYTE_W) r = r[BYTE_W-1] ? ({r[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
                                        : {r[BYTE_W-2:0], 1'b0};
        return r;
    endfunction

    // Queue one non-final frame byte and fold it into the running CRC.
    task automatic emit_byte(input logic [BYTE_W-1:0] b, inout logic [BYTE_W-1:0] crc);
        frame_expect.push_back('{data: b, is_last: 1'b0});
        crc = crc8_next(crc, b);
    endtask

    // Frame predictor: buffers one token and, when the chunk closes, queues
    // the whole frame that the block must send.
    task automatic frame_token(input logic [BYTE_W-1:0] tok, input logic is_last);
        int                lim;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] crc;
        lim = (cfg_limit == 0) ? 1 : ((int'(cfg_limit) > MAX_PAY) ? MAX_PAY : int'(cfg_limit));
        if (pm_fill < MAX_PAY) begin
            pm_chunk[pm_fill] = tok;
            pm_fill++;
        end
        if (!is_last && pm_fill < lim) begin
            return;
        end
        flags = '0;
        if (pm_first) begin
            pm_msg_id++;
            flags[FLG_START_BIT] = 1'b1;
        end
        if (is_last) begin
            flags[FLG_END_BIT] = 1'b1;
        end
        crc = CRC_INIT;
        emit_byte(SYNC_A, crc);
        emit_byte(SYNC_B, crc);
        emit_byte(pm_msg_id, crc);
        emit_byte(pm_seq, crc);
        emit_byte(flags, crc);
        emit_byte(BYTE_W'(pm_fill), crc);
        for (int i = 0; i < pm_fill; i++) begin
            emit_byte(pm_chunk[i], crc);
        end
        frame_expect.push_back('{data: crc, is_last: 1'b1});
        pm_seq++;
        pm_fill  = 0;
        pm_first = is_last;
    endtask

    // Monitor: checks frame bytes, then tracks configuration and token
    // requests accepted at this edge.
    always @(posedge i_clk) begin
        t_frame_beat want;
        if (!i_rst_n) begin
            tok_taken <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (frame_expect.size() == 0) begin
                    $display("%0t: unexpected frame byte %02h (last %0b)",
                             $time, o_frame_byte, o_frame_last);
                    error_count++;
                end else begin
                    want = frame_expect.pop_front();
                    byte_count++;
                    if (o_frame_byte !== want.data) begin
                        $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, o_frame_byte);
                        error_count++;
                    end
                    if (o_frame_last !== want.is_last) begin
                        $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                                 $time, want.is_last, o_frame_last);
                        error_count++;
                    end
                    if (want.is_last) begin
                        frame_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_limit = i_cfg_payload_limit;
                cfg_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                frame_token(i_token, i_last_token);
                tok_count++;
            end
            tok_taken <= i_in_valid && o_in_ready;
        end
    end

    // Driver: offers token requests in bursts with random gaps between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tok_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_tokens.size() > 0) begin
                cur_req = pending_tokens.pop_front();
                i_token      <= cur_req.tok;
                i_last_token <= cur_req.is_last;
                i_in_valid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns and twice holds off for a
    // long stretch so that the input side backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_left == 0 && holds_done < 2 &&
                tok_count >= ((holds_done == 0) ? 120 : 320)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (rx_span == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_span = $urandom_range(16, 128);
            end else begin
                rx_span--;
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    default:   i_out_ready <= (rx_tick % 4 == 0);
                endcase
            end
        end
    end

    task automatic add_token(input logic [BYTE_W-1:0] tok, input logic is_last);
        pending_tokens.push_back('{tok: tok, is_last: is_last});
    endtask

    // Wait until every request is sent and every frame byte has arrived.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_tokens.size() != 0 || i_in_valid || frame_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Payload limit write; only called while the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_payload_limit <= value;
        i_cfg_valid         <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus sequence and end of run.
    initial begin
        int rnd_items;
        int n_msgs;
        int len;
        int sel;
        rnd_items = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-token messages at the reset limit, extreme token values.
        add_token(8'hFF, 1'b1);
        add_token(8'h00, 1'b1);
        wait_idle();
        // Limit of one: every token makes its own frame.
        write_limit(LIMIT_W'(1));
        add_token(8'hA5, 1'b0);
        add_token(8'h5A, 1'b1);
        wait_idle();
        // A limit of zero behaves as one.
        write_limit(LIMIT_W'(0));
        add_token(8'h01, 1'b0);
        add_token(8'h80, 1'b1);
        wait_idle();
        // Chunk fills exactly on the last token.
        write_limit(LIMIT_W'(2));
        add_token(8'h3C, 1'b0);
        add_token(8'hC3, 1'b1);
        wait_idle();
        // Limit lowered with three bytes buffered: next token sends four.
        write_limit(LIMIT_W'(5));
        add_token(8'h11, 1'b0);
        add_token(8'h22, 1'b0);
        add_token(8'h33, 1'b0);
        wait_idle();
        write_limit(LIMIT_W'(2));
        add_token(8'h44, 1'b0);
        wait_idle();
        add_token(8'h55, 1'b1);
        wait_idle();
        // Limit above the buffer size.
        write_limit(LIMIT_W'(31));
        add_token(8'h7E, 1'b0);
        add_token(8'h81, 1'b0);
        add_token(8'hE7, 1'b1);
        wait_idle();

        // Random phases: a limit setting, then a few messages with the odd
        // noise run where last marks fall at random.
        while (rnd_items < RAND_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       write_limit(LIMIT_W'(0));
                1:       write_limit(LIMIT_W'(1));
                2:       write_limit(LIMIT_W'(MAX_PAY));
                3:       write_limit(LIMIT_W'(31));
                default: write_limit(LIMIT_W'($urandom_range(0, 31)));
            endcase
            n_msgs = $urandom_range(1, 6);
            for (int m = 0; m < n_msgs; m++) begin
                if ($urandom_range(0, 4) == 0) begin
                    len = $urandom_range(1, 20);
                    for (int k = 0; k < len; k++) begin
                        add_token(BYTE_W'($urandom), ($urandom_range(0, 3) == 0));
                    end
                end else begin
                    sel = $urandom_range(0, 19);
                    if (sel < 8) begin
                        len = $urandom_range(1, 3);
                    end else if (sel < 17) begin
                        len = $urandom_range(4, 12);
                    end else begin
                        len = $urandom_range(13, 40);
                    end
                    for (int k = 0; k < len; k++) begin
                        add_token(BYTE_W'($urandom), (k == len - 1));
                    end
                end
                rnd_items += len;
            end
            wait_idle();
        end

        $display("Sent %0d token requests as %0d frames, %0d frame bytes checked.",
                 tok_count, frame_count, byte_count);
        $display("Payload limit written %0d times, %0d long receiver hold-offs.",
                 cfg_writes, holds_done);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d frame bytes still expected.", frame_expect.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
